// ===== rtl/ppp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants and types for the point perspective projector.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COEFF_FRAC_BITS = 12;

  localparam int COORD_W = 32;
  localparam int COEFF_W = 16;
  localparam int PROD_W  = COORD_W + COEFF_W;   // one coefficient product
  localparam int SUM_W   = PROD_W + 4;          // sum of four terms, with margin
  localparam int MAG_W   = SUM_W;               // magnitude of a sum
  localparam int QUO_W   = 32;                  // quotient bits before saturation

  // Divider latency from its input to its registered result, and whole pipe
  localparam int DIV_LAT  = QUO_W + 2;
  localparam int PIPE_LAT = DIV_LAT + 3;

  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROW_X    = 8'd0,
    REG_ROW_Y    = 8'd1,
    REG_ROW_W    = 8'd2,
    REG_DFLT_CLR = 8'd3,
    REG_DFLT_SZ  = 8'd4,
    REG_ATTR_MD  = 8'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] size;
    logic [31:0] color;
  } attr_t;

endpackage

// ===== rtl/point_perspective_projector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_perspective_projector
// Projects Q16.16 points through three Q4.12 matrix rows and divides by w.
// ----------------------------------------------------------------------------
// Accepts one point per clock while the output is not stalled. Each point
// passes multiply, sum and magnitude stages, then a divider that retires
// one quotient bit per stage. Points whose clip w is zero are dropped. The
// whole pipe holds when the output transaction is stalled. Configuration
// writes are always ready and take effect on the next accepted point.
// ----------------------------------------------------------------------------
module point_perspective_projector
  import ppp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // coord_x, coord_y, coord_z, point_color, point_size
  input  logic [143:0]          in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // ndc_x, ndc_y, marker_color, marker_size
  output logic [111:0]          out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [63:0] row_r [0:2];
  logic [31:0] dflt_color_r;
  logic [15:0] dflt_size_r;
  logic [1:0]  mode_r;

  logic        ce;
  logic        vld_r  [0:PIPE_LAT-1];
  attr_t       attr_r [0:PIPE_LAT-1];
  attr_t       attr_nxt;

  logic signed [PROD_W-1:0] prod_r [0:2][0:2];
  logic signed [SUM_W-1:0]  kterm_r[0:2];
  logic signed [SUM_W-1:0]  sum_r  [0:2];
  logic [MAG_W-1:0]         mag_r  [0:2];
  logic                     sgn_r  [0:2];
  logic signed [QUO_W-1:0]  ndc_x, ndc_y;

  logic signed [COORD_W-1:0] pt [0:2];

  assign pt[0] = in_tdata[31:0];
  assign pt[1] = in_tdata[63:32];
  assign pt[2] = in_tdata[95:64];

  assign ce        = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready = ce;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]     <= '0;
      row_r[1]     <= '0;
      row_r[2]     <= '0;
      dflt_color_r <= 32'hFFFF_FFFF;
      dflt_size_r  <= 16'd256;
      mode_r       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_ROW_X:    row_r[0]     <= cfg_data;
        REG_ROW_Y:    row_r[1]     <= cfg_data;
        REG_ROW_W:    row_r[2]     <= cfg_data;
        REG_DFLT_CLR: dflt_color_r <= cfg_data[31:0];
        REG_DFLT_SZ:  dflt_size_r  <= cfg_data[15:0];
        REG_ATTR_MD:  mode_r       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // attribute selection at entry
  always_comb begin
    attr_nxt.color = mode_r[0] ? in_tdata[127:96]  : dflt_color_r;
    attr_nxt.size  = mode_r[1] ? in_tdata[143:128] : dflt_size_r;
  end

  // valid and attribute shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PIPE_LAT; s++) vld_r[s] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_tvalid;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1] && (sum_r[2] != '0);
      for (int s = 3; s < PIPE_LAT; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      attr_r[0] <= attr_nxt;
      for (int s = 1; s < PIPE_LAT; s++) attr_r[s] <= attr_r[s-1];
    end
  end

  // stage 1 products, stage 2 sums, stage 3 magnitudes
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= $signed(row_r[r][16*c +: 16]) * pt[c];
        end
        kterm_r[r] <= {{(SUM_W-COEFF_W-COORD_FRAC_BITS){row_r[r][63]}},
                       row_r[r][63:48], {COORD_FRAC_BITS{1'b0}}};
        sum_r[r] <= SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) +
                    SUM_W'(prod_r[r][2]) + kterm_r[r];
        mag_r[r] <= sum_r[r][SUM_W-1] ? MAG_W'('0 - sum_r[r]) : MAG_W'(sum_r[r]);
        sgn_r[r] <= sum_r[r][SUM_W-1];
      end
    end
  end

  // divide x and y by w
  ppp_frac_div u_div_x (
    .clk     (clk),
    .ce      (ce),
    .num_mag (mag_r[0]),
    .den_mag (mag_r[2]),
    .neg     (sgn_r[0] ^ sgn_r[2]),
    .quo     (ndc_x)
  );

  ppp_frac_div u_div_y (
    .clk     (clk),
    .ce      (ce),
    .num_mag (mag_r[1]),
    .den_mag (mag_r[2]),
    .neg     (sgn_r[1] ^ sgn_r[2]),
    .quo     (ndc_y)
  );

  assign out_tvalid = vld_r[PIPE_LAT-1];
  assign out_tdata  = {attr_r[PIPE_LAT-1].size, attr_r[PIPE_LAT-1].color, ndc_y, ndc_x};

  // a point that reaches the divider never has zero w
  a_w_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> u_div_x.den_r[0] != '0) else $error("zero w entered divider");

  // a stalled result is kept
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result lost");

endmodule

// ===== rtl/ppp_frac_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_frac_div
// Pipelined restoring divider: one quotient bit per stage, giving
// num / den with COORD_FRAC_BITS fraction bits, truncated and saturated.
// ----------------------------------------------------------------------------
module ppp_frac_div
  import ppp_pkg::*;
(
  input  logic                    clk,
  input  logic                    ce,
  input  logic [MAG_W-1:0]        num_mag,
  input  logic [MAG_W-1:0]        den_mag,
  input  logic                    neg,
  output logic signed [QUO_W-1:0] quo
);

  logic [MAG_W-1:0]   rem_r [0:QUO_W];
  logic [MAG_W-1:0]   den_r [0:QUO_W];
  logic [QUO_W-1:0]   bits_r[0:QUO_W];
  logic [QUO_W-1:0]   q_r   [0:QUO_W];
  logic               sat_r [0:QUO_W];
  logic               neg_r [0:QUO_W];
  logic [QUO_W-1:0]   quo_r;

  logic [MAG_W-1:0]   rem_nxt[1:QUO_W];
  logic               qb_nxt [1:QUO_W];

  logic               sat_in;
  logic [QUO_W-1:0]   quo_nxt;

  // integer part too large once the quotient reaches 2^(32-FRAC)
  assign sat_in = {{COORD_FRAC_BITS{1'b0}}, num_mag} >=
                  {den_mag, {COORD_FRAC_BITS{1'b0}}};

  // one trial subtraction per stage
  always_comb begin
    for (int k = 1; k <= QUO_W; k++) begin
      logic [MAG_W:0] t;
      t = {rem_r[k-1], bits_r[k-1][QUO_W-1]};
      if (t >= {1'b0, den_r[k-1]}) begin
        t = t - {1'b0, den_r[k-1]};
        qb_nxt[k] = 1'b1;
      end else begin
        qb_nxt[k] = 1'b0;
      end
      rem_nxt[k] = t[MAG_W-1:0];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0]  <= num_mag >> COORD_FRAC_BITS;
      bits_r[0] <= {num_mag[COORD_FRAC_BITS-1:0], {(QUO_W-COORD_FRAC_BITS){1'b0}}};
      den_r[0]  <= den_mag;
      q_r[0]    <= '0;
      sat_r[0]  <= sat_in;
      neg_r[0]  <= neg;
      for (int k = 1; k <= QUO_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        bits_r[k] <= bits_r[k-1] << 1;
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][QUO_W-2:0], qb_nxt[k]};
        sat_r[k]  <= sat_r[k-1];
        neg_r[k]  <= neg_r[k-1];
      end
      quo_r <= quo_nxt;
    end
  end

  // sign and saturation
  always_comb begin
    if (neg_r[QUO_W]) begin
      if (sat_r[QUO_W] || q_r[QUO_W][QUO_W-1]) quo_nxt = {1'b1, {(QUO_W-1){1'b0}}};
      else                                     quo_nxt = '0 - q_r[QUO_W];
    end else begin
      if (sat_r[QUO_W] || q_r[QUO_W][QUO_W-1]) quo_nxt = {1'b0, {(QUO_W-1){1'b1}}};
      else                                     quo_nxt = q_r[QUO_W];
    end
  end

  assign quo = quo_r;

endmodule
